FILE: hw/rtl/spherize_source_coordinate_top_assert.svh
// assertion macros used by the checker of the spherize block
`ifndef SPHERIZE_SOURCE_COORDINATE_TOP_ASSERT_SVH
`define SPHERIZE_SOURCE_COORDINATE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Fixed-point widths, register indexes and the arctangent table of the
// spherize source coordinate pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // register indexes of the configuration channel
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  // q1.16 ratio and root width (holds 1.0)
  localparam int RT_W = 17;
  localparam logic [RT_W-1:0] Q_ONE = 17'h10000;

  // square root cells: 34-bit radicand, two bits per cell
  localparam int SQ_N_W  = 34;
  localparam int SQ_R_W  = 20;
  localparam int SQ_STEPS = 17;
  localparam logic [SQ_N_W-1:0] SQ_ONE = 34'h1_0000_0000;

  // ratio division: 33 quotient bits, one per cell
  localparam int DIV1_Q_W = 33;
  localparam int DIV1_L_W = 33;

  // offset division remainder width (divisor 2r is 18 bits)
  localparam int OFS_R_W = RT_W + 2;

  // cordic datapath width
  localparam int CX_W = 20;

  // atan(2^-i) / (pi/2) in q1.16
  function automatic logic signed [CX_W-1:0] angle_q16(int idx);
    logic signed [CX_W-1:0] v;
    case (idx)
      0:  v = CX_W'(32768);
      1:  v = CX_W'(19344);
      2:  v = CX_W'(10221);
      3:  v = CX_W'(5188);
      4:  v = CX_W'(2604);
      5:  v = CX_W'(1303);
      6:  v = CX_W'(652);
      7:  v = CX_W'(326);
      8:  v = CX_W'(163);
      9:  v = CX_W'(81);
      10: v = CX_W'(41);
      11: v = CX_W'(20);
      12: v = CX_W'(10);
      13: v = CX_W'(5);
      14: v = CX_W'(3);
      15: v = CX_W'(1);
      16: v = CX_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/ssc_div_cell.sv
// ----------------------------------------------------------------------------
// ssc_div_cell
// One restoring division step: shifts in one dividend bit, subtracts the
// divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module ssc_div_cell #(
  parameter int RW = 25,
  parameter int LW = 33,
  parameter int QW = 33,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_up,
  input  logic [RW-1:0] rem_up,
  input  logic [LW-1:0] low_up,
  input  logic [RW-2:0] den_up,
  input  logic [QW-1:0] quo_up,
  input  logic [SW-1:0] side_up,
  output logic          vld,
  output logic [RW-1:0] rem,
  output logic [LW-1:0] low,
  output logic [RW-2:0] den,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side
);

  logic [RW-1:0] trial;
  logic [RW-1:0] diff;
  logic          ge;

  assign trial = {rem_up[RW-2:0], low_up[LW-1]};
  assign diff  = trial - {1'b0, den_up};
  assign ge    = trial >= {1'b0, den_up};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_up;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff : trial;
      low  <= {low_up[LW-2:0], 1'b0};
      den  <= den_up;
      quo  <= {quo_up[QW-2:0], ge};
      side <= side_up;
    end
  end

endmodule

FILE: hw/rtl/ssc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssc_sqrt_cell
// One digit-by-digit square root step: brings in two radicand bits and
// settles one root bit.
// ----------------------------------------------------------------------------
module ssc_sqrt_cell import ssc_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_up,
  input  logic [SQ_N_W-1:0] n_up,
  input  logic [SQ_R_W-1:0] rm_up,
  input  logic [RT_W-1:0]   root_up,
  input  logic [SW-1:0]     side_up,
  output logic              vld,
  output logic [SQ_N_W-1:0] n,
  output logic [SQ_R_W-1:0] rm,
  output logic [RT_W-1:0]   root,
  output logic [SW-1:0]     side
);

  logic [SQ_R_W-1:0] trial;
  logic [SQ_R_W-1:0] tst;
  logic              ge;

  // remainder stays below 2*root + 1, so its low bits carry everything
  assign trial = {rm_up[SQ_R_W-3:0], n_up[SQ_N_W-1 -: 2]};
  assign tst   = SQ_R_W'({root_up, 2'b01});
  assign ge    = trial >= tst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_up;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm   <= ge ? trial - tst : trial;
      root <= {root_up[RT_W-2:0], ge};
      n    <= {n_up[SQ_N_W-3:0], 2'b00};
      side <= side_up;
    end
  end

endmodule

FILE: hw/rtl/ssc_cordic_cell.sv
// ----------------------------------------------------------------------------
// ssc_cordic_cell
// One vectoring cordic rotation: drives y toward zero and accumulates the
// normalized angle.
// ----------------------------------------------------------------------------
module ssc_cordic_cell import ssc_pkg::*; #(
  parameter int STAGE = 0,
  parameter int SW    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vld_up,
  input  logic signed [CX_W-1:0] x_up,
  input  logic signed [CX_W-1:0] y_up,
  input  logic signed [CX_W-1:0] z_up,
  input  logic [SW-1:0]          side_up,
  output logic                   vld,
  output logic signed [CX_W-1:0] x,
  output logic signed [CX_W-1:0] y,
  output logic signed [CX_W-1:0] z,
  output logic [SW-1:0]          side
);

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic signed [CX_W-1:0] ang;
  logic                   neg;

  assign xs  = x_up >>> STAGE;
  assign ys  = y_up >>> STAGE;
  assign ang = angle_q16(STAGE);
  assign neg = y_up[CX_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_up;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= neg ? x_up - ys : x_up + ys;
      y    <= neg ? y_up + xs : y_up - xs;
      z    <= neg ? z_up - ang : z_up + ang;
      side <= side_up;
    end
  end

endmodule

FILE: hw/rtl/spherize_source_coordinate_top.sv
// ----------------------------------------------------------------------------
// spherize_source_coordinate_top
// Spherize warp source coordinate: one pixel in, one warped pixel out.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock while the skid stage is empty and
// returns one result per pixel, in order. The path is a row of cells: a
// 33-cell divider for d^2/R^2, two 17-cell square roots, the cordic arcsine
// cells and a COORD_BITS-cell divider per axis for the final scaling. The
// whole row advances together; a skid stage at the output holds one extra
// result, so input is refused only while it holds one, which happens when a
// new result arrives while the output is held. Write the configuration only
// while no pixel is in flight.
module spherize_source_coordinate_top import ssc_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pixel_x, pixel_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // source_x, source_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // inside_res
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int CS   = CORDIC_STAGES;
  localparam int IO_W = ((2*CB+7)/8)*8;
  localparam int R1_W = 2*CB+1;
  localparam int SW1  = 4*CB+4;
  localparam int SW2  = SW1 + RT_W;
  localparam int SW3  = 2*CB+3;
  localparam int PR_W = CB + RT_W;
  localparam int NUM_W = CB + OFS_R_W;

  // configuration
  logic [CB-1:0]   center_x;
  logic [CB-1:0]   center_y;
  logic [CB-1:0]   radius;
  logic [2*CB-1:0] r2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= CB'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= radius * radius;
  end

  // row advance
  logic en;
  logic skid_vld;

  assign en       = !skid_vld;
  assign s_tready = en;

  // offsets and squares
  logic                 v0, v1;
  logic [CB-1:0]        px0, py0, px1, py1;
  logic signed [CB:0]   dx0, dy0, dx1, dy1;
  logic signed [2*CB+1:0] dxp, dyp;
  logic [2*CB-1:0]      dxsq1, dysq1;

  assign dxp = dx0 * dx0;
  assign dyp = dy0 * dy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0   <= s_tdata[CB-1:0];
      py0   <= s_tdata[2*CB-1:CB];
      dx0   <= $signed({1'b0, s_tdata[CB-1:0]}) - $signed({1'b0, center_x});
      dy0   <= $signed({1'b0, s_tdata[2*CB-1:CB]}) - $signed({1'b0, center_y});
      px1   <= px0;
      py1   <= py0;
      dx1   <= dx0;
      dy1   <= dy0;
      dxsq1 <= dxp[2*CB-1:0];
      dysq1 <= dyp[2*CB-1:0];
    end
  end

  logic [R1_W-1:0] d2;
  logic            inside1, spec1;

  assign d2      = {1'b0, dxsq1} + {1'b0, dysq1};
  assign inside1 = d2 <= {1'b0, r2};
  assign spec1   = (d2 == '0) || (r2 == '0);

  // ratio division: q = d2 * 2^32 / r2, starting from d2 >> 1
  logic                dv_vld  [0:DIV1_Q_W];
  logic [R1_W-1:0]     dv_rem  [0:DIV1_Q_W];
  logic [DIV1_L_W-1:0] dv_low  [0:DIV1_Q_W];
  logic [R1_W-2:0]     dv_den  [0:DIV1_Q_W];
  logic [DIV1_Q_W-1:0] dv_quo  [0:DIV1_Q_W];
  logic [SW1-1:0]      dv_side [0:DIV1_Q_W];

  assign dv_vld[0]  = v1;
  assign dv_rem[0]  = {1'b0, d2[R1_W-1:1]};
  assign dv_low[0]  = {d2[0], {(DIV1_L_W-1){1'b0}}};
  assign dv_den[0]  = r2;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {inside1, spec1, px1, py1, dx1, dy1};

  for (genvar k = 0; k < DIV1_Q_W; k++) begin : g_div1
    ssc_div_cell #(.RW(R1_W), .LW(DIV1_L_W), .QW(DIV1_Q_W), .SW(SW1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(dv_vld[k]), .rem_up(dv_rem[k]), .low_up(dv_low[k]),
      .den_up(dv_den[k]), .quo_up(dv_quo[k]), .side_up(dv_side[k]),
      .vld(dv_vld[k+1]), .rem(dv_rem[k+1]), .low(dv_low[k+1]),
      .den(dv_den[k+1]), .quo(dv_quo[k+1]), .side(dv_side[k+1])
    );
  end

  // r = isqrt(q)
  logic              s1_vld  [0:SQ_STEPS];
  logic [SQ_N_W-1:0] s1_n    [0:SQ_STEPS];
  logic [SQ_R_W-1:0] s1_rm   [0:SQ_STEPS];
  logic [RT_W-1:0]   s1_root [0:SQ_STEPS];
  logic [SW1-1:0]    s1_side [0:SQ_STEPS];

  assign s1_vld[0]  = dv_vld[DIV1_Q_W];
  assign s1_n[0]    = SQ_N_W'(dv_quo[DIV1_Q_W]);
  assign s1_rm[0]   = '0;
  assign s1_root[0] = '0;
  assign s1_side[0] = dv_side[DIV1_Q_W];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt1
    ssc_sqrt_cell #(.SW(SW1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(s1_vld[k]), .n_up(s1_n[k]), .rm_up(s1_rm[k]),
      .root_up(s1_root[k]), .side_up(s1_side[k]),
      .vld(s1_vld[k+1]), .n(s1_n[k+1]), .rm(s1_rm[k+1]),
      .root(s1_root[k+1]), .side(s1_side[k+1])
    );
  end

  // clamp r, then r*r
  logic              v4, v5;
  logic [RT_W-1:0]   rc4, rc5;
  logic [SW1-1:0]    sd4, sd5;
  logic [SQ_N_W-1:0] rsq5;
  logic [RT_W-1:0]   root_last;

  assign root_last = s1_root[SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= s1_vld[SQ_STEPS];
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (root_last == '0) begin
        rc4 <= RT_W'(1);
      end else if (root_last > Q_ONE) begin
        rc4 <= Q_ONE;
      end else begin
        rc4 <= root_last;
      end
      sd4  <= s1_side[SQ_STEPS];
      rc5  <= rc4;
      sd5  <= sd4;
      rsq5 <= SQ_N_W'(rc4) * SQ_N_W'(rc4);
    end
  end

  // c = isqrt(1 - r^2)
  logic              s2_vld  [0:SQ_STEPS];
  logic [SQ_N_W-1:0] s2_n    [0:SQ_STEPS];
  logic [SQ_R_W-1:0] s2_rm   [0:SQ_STEPS];
  logic [RT_W-1:0]   s2_root [0:SQ_STEPS];
  logic [SW2-1:0]    s2_side [0:SQ_STEPS];

  assign s2_vld[0]  = v5;
  assign s2_n[0]    = SQ_ONE - rsq5;
  assign s2_rm[0]   = '0;
  assign s2_root[0] = '0;
  assign s2_side[0] = {rc5, sd5};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt2
    ssc_sqrt_cell #(.SW(SW2)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(s2_vld[k]), .n_up(s2_n[k]), .rm_up(s2_rm[k]),
      .root_up(s2_root[k]), .side_up(s2_side[k]),
      .vld(s2_vld[k+1]), .n(s2_n[k+1]), .rm(s2_rm[k+1]),
      .root(s2_root[k+1]), .side(s2_side[k+1])
    );
  end

  // arcsine by vectoring cordic on (c, r)
  logic                   cx_vld  [0:CS];
  logic signed [CX_W-1:0] cx_x    [0:CS];
  logic signed [CX_W-1:0] cx_y    [0:CS];
  logic signed [CX_W-1:0] cx_z    [0:CS];
  logic [SW2-1:0]         cx_side [0:CS];

  assign cx_vld[0]  = s2_vld[SQ_STEPS];
  assign cx_x[0]    = CX_W'(s2_root[SQ_STEPS]);
  assign cx_y[0]    = CX_W'(s2_side[SQ_STEPS][SW2-1 -: RT_W]);
  assign cx_z[0]    = '0;
  assign cx_side[0] = s2_side[SQ_STEPS];

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    ssc_cordic_cell #(.STAGE(k), .SW(SW2)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(cx_vld[k]), .x_up(cx_x[k]), .y_up(cx_y[k]), .z_up(cx_z[k]),
      .side_up(cx_side[k]),
      .vld(cx_vld[k+1]), .x(cx_x[k+1]), .y(cx_y[k+1]), .z(cx_z[k+1]),
      .side(cx_side[k+1])
    );
  end

  // clamp angle to [0, r], then scale the offset magnitudes
  logic                   v7, v8;
  logic [RT_W-1:0]        a7;
  logic [SW2-1:0]         sd7, sd8;
  logic [PR_W-1:0]        prx8, pry8;
  logic signed [CX_W-1:0] z_last;
  logic signed [CX_W-1:0] r_last;
  logic signed [CB:0]     dx7, dy7;
  logic [CB:0]            adx7, ady7;

  assign z_last = cx_z[CS];
  assign r_last = CX_W'(cx_side[CS][SW2-1 -: RT_W]);
  assign dx7    = sd7[2*CB+1:CB+1];
  assign dy7    = sd7[CB:0];
  assign adx7   = dx7[CB] ? -dx7 : dx7;
  assign ady7   = dy7[CB] ? -dy7 : dy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v7 <= cx_vld[CS];
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_last < 0) begin
        a7 <= '0;
      end else if (z_last > r_last) begin
        a7 <= r_last[RT_W-1:0];
      end else begin
        a7 <= z_last[RT_W-1:0];
      end
      sd7  <= cx_side[CS];
      sd8  <= sd7;
      prx8 <= adx7[CB-1:0] * a7;
      pry8 <= ady7[CB-1:0] * a7;
    end
  end

  // rounded offset = (2*|d|*a + r) / (2*r), one bit per cell per axis
  logic [RT_W-1:0]  r8;
  logic [NUM_W-1:0] numx, numy;
  logic [SW1-1:0]   s8;

  assign r8   = sd8[SW2-1 -: RT_W];
  assign s8   = sd8[SW1-1:0];
  assign numx = {prx8, 1'b0} + NUM_W'(r8);
  assign numy = {pry8, 1'b0} + NUM_W'(r8);

  logic               ox_vld  [0:CB];
  logic [OFS_R_W-1:0] ox_rem  [0:CB];
  logic [CB-1:0]      ox_low  [0:CB];
  logic [RT_W:0]      ox_den  [0:CB];
  logic [CB-1:0]      ox_quo  [0:CB];
  logic [SW3-1:0]     ox_side [0:CB];
  logic               oy_vld  [0:CB];
  logic [OFS_R_W-1:0] oy_rem  [0:CB];
  logic [CB-1:0]      oy_low  [0:CB];
  logic [RT_W:0]      oy_den  [0:CB];
  logic [CB-1:0]      oy_quo  [0:CB];
  logic               oy_side [0:CB];

  assign ox_vld[0]  = v8;
  assign ox_rem[0]  = numx[NUM_W-1:CB];
  assign ox_low[0]  = numx[CB-1:0];
  assign ox_den[0]  = {r8, 1'b0};
  assign ox_quo[0]  = '0;
  // inside, spec, px, py, sign of dx
  assign ox_side[0] = {s8[4*CB+3:2*CB+2], s8[2*CB+1]};
  assign oy_vld[0]  = v8;
  assign oy_rem[0]  = numy[NUM_W-1:CB];
  assign oy_low[0]  = numy[CB-1:0];
  assign oy_den[0]  = {r8, 1'b0};
  assign oy_quo[0]  = '0;
  assign oy_side[0] = s8[CB];

  for (genvar k = 0; k < CB; k++) begin : g_ofs
    ssc_div_cell #(.RW(OFS_R_W), .LW(CB), .QW(CB), .SW(SW3)) u_xcell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(ox_vld[k]), .rem_up(ox_rem[k]), .low_up(ox_low[k]),
      .den_up(ox_den[k]), .quo_up(ox_quo[k]), .side_up(ox_side[k]),
      .vld(ox_vld[k+1]), .rem(ox_rem[k+1]), .low(ox_low[k+1]),
      .den(ox_den[k+1]), .quo(ox_quo[k+1]), .side(ox_side[k+1])
    );
    ssc_div_cell #(.RW(OFS_R_W), .LW(CB), .QW(CB), .SW(1)) u_ycell (
      .clk(clk), .rst(rst), .en(en),
      .vld_up(oy_vld[k]), .rem_up(oy_rem[k]), .low_up(oy_low[k]),
      .den_up(oy_den[k]), .quo_up(oy_quo[k]), .side_up(oy_side[k]),
      .vld(oy_vld[k+1]), .rem(oy_rem[k+1]), .low(oy_low[k+1]),
      .den(oy_den[k+1]), .quo(oy_quo[k+1]), .side(oy_side[k+1])
    );
  end

  // add to center, saturate, pick the result
  logic [SW3-1:0]       fs;
  logic                 f_inside, f_spec, f_sdx, f_sdy;
  logic [CB-1:0]        f_px, f_py, f_qx, f_qy;
  logic signed [CB+1:0] sumx, sumy;
  logic signed [CB+1:0] cmax;
  logic [CB-1:0]        satx, saty;

  assign fs       = ox_side[CB];
  assign f_inside = fs[SW3-1];
  assign f_spec   = fs[SW3-2];
  assign f_px     = fs[2*CB:CB+1];
  assign f_py     = fs[CB:1];
  assign f_sdx    = fs[0];
  assign f_sdy    = oy_side[CB];
  assign f_qx     = ox_quo[CB];
  assign f_qy     = oy_quo[CB];
  assign cmax     = $signed({2'b00, {CB{1'b1}}});

  assign sumx = $signed({2'b00, center_x})
              + (f_sdx ? -$signed({2'b00, f_qx}) : $signed({2'b00, f_qx}));
  assign sumy = $signed({2'b00, center_y})
              + (f_sdy ? -$signed({2'b00, f_qy}) : $signed({2'b00, f_qy}));
  assign satx = (sumx < 0) ? '0 : ((sumx > cmax) ? {CB{1'b1}} : sumx[CB-1:0]);
  assign saty = (sumy < 0) ? '0 : ((sumy > cmax) ? {CB{1'b1}} : sumy[CB-1:0]);

  logic          fv;
  logic          f_in;
  logic [CB-1:0] f_x, f_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= ox_vld[CB] & oy_vld[CB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_in <= f_inside;
      if (!f_inside) begin
        f_x <= f_px;
        f_y <= f_py;
      end else if (f_spec) begin
        f_x <= center_x;
        f_y <= center_y;
      end else begin
        f_x <= satx;
        f_y <= saty;
      end
    end
  end

  // output register with one skid entry
  logic          out_in, skid_in;
  logic [CB-1:0] out_x, out_y, skid_x, skid_y;
  logic          load_out, load_skid, move_skid;

  assign move_skid = skid_vld && m_tready;
  assign load_out  = !skid_vld && fv && (!m_tvalid || m_tready);
  assign load_skid = !skid_vld && fv && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (move_skid) begin
        skid_vld <= 1'b0;
      end else if (load_skid) begin
        skid_vld <= 1'b1;
      end
      if (load_out || move_skid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_in <= skid_in;
      out_x  <= skid_x;
      out_y  <= skid_y;
    end else if (load_out) begin
      out_in <= f_in;
      out_x  <= f_x;
      out_y  <= f_y;
    end
    if (load_skid) begin
      skid_in <= f_in;
      skid_x  <= f_x;
      skid_y  <= f_y;
    end
  end

  assign m_tdata = IO_W'({out_y, out_x});
  assign m_tuser = out_in;

endmodule

FILE: hw/rtl/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the spherize source coordinate block.
// ----------------------------------------------------------------------------
`include "spherize_source_coordinate_top_assert.svh"

module ssc_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  input logic                                   m_tuser
);

  // a held result keeps its value
  `SSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "held result changed")

  // nothing comes out right after reset
  `SSC_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "result valid after reset")

  // input is refused only while a result sits unaccepted
  `SSC_ASSERT_NOW(a_ready_backpressure, !s_tready, m_tvalid && $past(m_tvalid && !m_tready), "input refused without output stall")

endmodule

bind spherize_source_coordinate_top ssc_checker #(.COORD_BITS(COORD_BITS)) u_ssc_checker (.*);
